// File: hdl/u8v_pkg.sv
`default_nettype none
package u8v_pkg;

  // Status codes of a verdict
  localparam logic [2:0] ST_VALID    = 3'd0;
  localparam logic [2:0] ST_BAD_LEAD = 3'd1;
  localparam logic [2:0] ST_TRUNC    = 3'd2;
  localparam logic [2:0] ST_BAD_CONT = 3'd3;
  localparam logic [2:0] ST_NONCANON = 3'd4;
  localparam logic [2:0] ST_CONTROL  = 3'd5;

  // Lead byte ranges, the ASCII limit, the lowest printable byte and the allowed control bytes
  localparam logic [7:0] LEAD2_LO   = 8'hc2;
  localparam logic [7:0] LEAD2_HI   = 8'hdf;
  localparam logic [7:0] LEAD3_LO   = 8'he0;
  localparam logic [7:0] LEAD3_HI   = 8'hef;
  localparam logic [7:0] LEAD4_LO   = 8'hf0;
  localparam logic [7:0] LEAD4_HI   = 8'hf4;
  localparam logic [7:0] ASCII_HI   = 8'h7f;
  localparam logic [7:0] PRINT_LO   = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;

  // Code point limits
  localparam logic [20:0] CP_MIN3   = 21'h000800;
  localparam logic [20:0] CP_MIN4   = 21'h010000;
  localparam logic [20:0] CP_MAX    = 21'h10ffff;
  localparam logic [20:0] SURR_LO   = 21'h00d800;
  localparam logic [20:0] SURR_HI   = 21'h00dfff;

  // Sequence lengths
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN2     = 3'd2;
  localparam logic [2:0] LEN3     = 3'd3;
  localparam logic [2:0] LEN4     = 3'd4;

  // One input item held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       end_of_document;
  } stage_t;

endpackage
`default_nettype wire

// File: hdl/u8v_in_if.sv
`default_nettype none
interface u8v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_document;

  modport source(output valid, output data_byte, output end_of_document, input ready);
  modport sink(input valid, input data_byte, input end_of_document, output ready);
endinterface
`default_nettype wire

// File: hdl/u8v_out_if.sv
`default_nettype none
interface u8v_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status_code;

  modport source(output valid, output status_code, input ready);
  modport sink(input valid, input status_code, output ready);
endinterface
`default_nettype wire

// File: hdl/utf8_stream_validator.sv
// Strict UTF-8 checker, one byte per transfer, one verdict per document.
// A verdict passes through the input register and then the result register on its way to the result port.
// Throughput: 1 byte per cycle while the result port does not stall; the sequence state is updated in a single pass.
// A stalled result port holds the input register and then the input port.
// Reset (rst_n low, synchronous) empties both registers and clears the state.
`default_nettype none
module utf8_stream_validator (
  input  wire logic clk,
  input  wire logic rst_n,
  u8v_in_if.sink    in_chan,
  u8v_out_if.source out_chan
);

  u8v_pkg::stage_t stage;
  logic            take;

  u8v_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .take    (take),
    .stage   (stage)
  );

  u8v_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .stage    (stage),
    .take     (take),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire

// File: hdl/u8v_in_stage.sv
`default_nettype none
module u8v_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  u8v_in_if.sink              in_chan,
  input  wire logic           take,
  output u8v_pkg::stage_t     stage
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       eod_r;
  logic       accept;

  // Accept a new transfer when the register is empty or drains this cycle
  assign in_chan.ready = !valid_r || take;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load payload on each accepted transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_chan.data_byte;
      eod_r  <= in_chan.end_of_document;
    end
  end

  assign stage.valid           = valid_r;
  assign stage.data_byte       = byte_r;
  assign stage.end_of_document = eod_r;

endmodule
`default_nettype wire

// File: hdl/u8v_core.sv
`default_nettype none
module u8v_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire u8v_pkg::stage_t stage,
  output logic                take,
  u8v_out_if.source           out_chan
);

  // Decoder state
  logic [1:0]  rem_r, rem_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [20:0] code_r, code_nxt;
  logic        cerr_r, cerr_nxt;
  logic        vdone_r, vdone_nxt;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  status_r;

  logic [7:0]  b;
  logic        last;
  logic [2:0]  status;
  logic        emit;
  logic        out_free;

  assign b    = stage.data_byte;
  assign last = stage.end_of_document;

  // Advance when the result register is empty or drains this cycle
  assign out_free = !out_valid_r || out_chan.ready;
  assign take     = stage.valid && out_free;

  // Decode one byte against the current sequence state
  always_comb begin
    rem_nxt   = rem_r;
    len_nxt   = len_r;
    code_nxt  = code_r;
    cerr_nxt  = cerr_r;
    vdone_nxt = vdone_r;
    status    = u8v_pkg::ST_VALID;
    emit      = 1'b0;

    if (!vdone_r) begin
      if (rem_r == 2'd0) begin
        if (b <= u8v_pkg::ASCII_HI) begin
          if (b < u8v_pkg::PRINT_LO && !(b inside {u8v_pkg::CHAR_TAB, u8v_pkg::CHAR_LF,
                                                  u8v_pkg::CHAR_CR})) begin
            status = u8v_pkg::ST_CONTROL;
          end
        end else if (b inside {[u8v_pkg::LEAD2_LO:u8v_pkg::LEAD2_HI]}) begin
          len_nxt  = u8v_pkg::LEN2;
          code_nxt = {16'd0, b[4:0]};
          rem_nxt  = 2'd1;
          cerr_nxt = 1'b0;
        end else if (b inside {[u8v_pkg::LEAD3_LO:u8v_pkg::LEAD3_HI]}) begin
          len_nxt  = u8v_pkg::LEN3;
          code_nxt = {17'd0, b[3:0]};
          rem_nxt  = 2'd2;
          cerr_nxt = 1'b0;
        end else if (b inside {[u8v_pkg::LEAD4_LO:u8v_pkg::LEAD4_HI]}) begin
          len_nxt  = u8v_pkg::LEN4;
          code_nxt = {18'd0, b[2:0]};
          rem_nxt  = 2'd3;
          cerr_nxt = 1'b0;
        end else begin
          status = u8v_pkg::ST_BAD_LEAD;
        end
      end else begin
        // Gather a continuation; hold a bad one until the sequence closes
        if (b[7:6] != 2'b10) begin
          cerr_nxt = 1'b1;
        end
        code_nxt = {code_r[14:0], b[5:0]};
        rem_nxt  = rem_r - 2'd1;
        if (rem_nxt == 2'd0) begin
          if (cerr_nxt) begin
            status = u8v_pkg::ST_BAD_CONT;
          end else if ((len_r == u8v_pkg::LEN3 && code_nxt < u8v_pkg::CP_MIN3) ||
                       (len_r == u8v_pkg::LEN4 && code_nxt < u8v_pkg::CP_MIN4) ||
                       code_nxt > u8v_pkg::CP_MAX ||
                       (code_nxt >= u8v_pkg::SURR_LO && code_nxt <= u8v_pkg::SURR_HI)) begin
            status = u8v_pkg::ST_NONCANON;
          end
        end
      end

      // Final byte without an error: open sequence means truncation
      if (status == u8v_pkg::ST_VALID && last && rem_nxt != 2'd0) begin
        status = u8v_pkg::ST_TRUNC;
      end
      emit      = (status != u8v_pkg::ST_VALID) || last;
      vdone_nxt = emit;
    end

    // Clear everything at the end of a document
    if (last) begin
      rem_nxt   = 2'd0;
      len_nxt   = u8v_pkg::LEN_NONE;
      code_nxt  = 21'd0;
      cerr_nxt  = 1'b0;
      vdone_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r   <= 2'd0;
      len_r   <= u8v_pkg::LEN_NONE;
      code_r  <= 21'd0;
      cerr_r  <= 1'b0;
      vdone_r <= 1'b0;
    end else if (take) begin
      rem_r   <= rem_nxt;
      len_r   <= len_nxt;
      code_r  <= code_nxt;
      cerr_r  <= cerr_nxt;
      vdone_r <= vdone_nxt;
    end
  end

  // Result register: load on a verdict, drop once transferred
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = emit;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      status_r <= status;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status_code = status_r;

  // Checks
  a_no_second_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (take && vdone_r) |-> !emit)
    else $error("verdict emitted twice for one document");

  a_clear_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (take && last) |=> (rem_r == 2'd0 && !vdone_r && !cerr_r))
    else $error("state not cleared after end of document");

  a_rem_fits_len: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r != 2'd0) |-> ({1'b0, rem_r} < len_r && len_r >= u8v_pkg::LEN2))
    else $error("pending continuations exceed sequence length");

  a_verdict_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (take && emit) |=> out_valid_r)
    else $error("verdict not presented");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (status_r <= u8v_pkg::ST_CONTROL))
    else $error("status code out of range");

endmodule
`default_nettype wire

// File: sim/tb_utf8_stream_validator.sv
`timescale 1ns / 1ps
module tb_utf8_stream_validator;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_BYTES  = 350;
  localparam int NUM_PHASES   = 4;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_document;
  } doc_byte_t;

  logic clk;
  logic rst_n;

  u8v_in_if  in_bus();
  u8v_out_if out_bus();

  utf8_stream_validator DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  // Stimulus feed and expected verdicts
  doc_byte_t  pending_bytes[$];
  logic [2:0] expected_verdicts[$];
  logic [7:0] doc[$];
  int         bytes_queued;

  // Handshake pacing, in percent
  int send_idle_pct;
  int stall_pct;

  bit         in_fire;
  int         cycle_count;
  int         fault_count;
  logic [2:0] want_status;
  doc_byte_t  next_item;

  // Decoder state of the checker
  logic [1:0]  cont_left;
  logic [2:0]  seq_len;
  logic [20:0] code_acc;
  logic        cont_bad;
  logic        verdict_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic clear_decoder();
    cont_left    = 2'd0;
    seq_len      = u8v_pkg::LEN_NONE;
    code_acc     = 21'd0;
    cont_bad     = 1'b0;
    verdict_sent = 1'b0;
  endtask

  // Advance the decoder by one byte; return an error status or ST_VALID
  task automatic decode_byte(input logic [7:0] b, output logic [2:0] st);
    st = u8v_pkg::ST_VALID;
    if (cont_left == 2'd0) begin
      if (b <= u8v_pkg::ASCII_HI) begin
        if (b < u8v_pkg::PRINT_LO && b != u8v_pkg::CHAR_TAB && b != u8v_pkg::CHAR_LF &&
            b != u8v_pkg::CHAR_CR)
          st = u8v_pkg::ST_CONTROL;
      end else if (b >= u8v_pkg::LEAD2_LO && b <= u8v_pkg::LEAD2_HI) begin
        seq_len   = u8v_pkg::LEN2;
        code_acc  = {16'd0, b[4:0]};
        cont_left = 2'd1;
        cont_bad  = 1'b0;
      end else if (b >= u8v_pkg::LEAD3_LO && b <= u8v_pkg::LEAD3_HI) begin
        seq_len   = u8v_pkg::LEN3;
        code_acc  = {17'd0, b[3:0]};
        cont_left = 2'd2;
        cont_bad  = 1'b0;
      end else if (b >= u8v_pkg::LEAD4_LO && b <= u8v_pkg::LEAD4_HI) begin
        seq_len   = u8v_pkg::LEN4;
        code_acc  = {18'd0, b[2:0]};
        cont_left = 2'd3;
        cont_bad  = 1'b0;
      end else begin
        st = u8v_pkg::ST_BAD_LEAD;
      end
    end else begin
      if (b[7:6] != 2'b10)
        cont_bad = 1'b1;
      code_acc  = {code_acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        if (cont_bad)
          st = u8v_pkg::ST_BAD_CONT;
        else if ((seq_len == u8v_pkg::LEN3 && code_acc < u8v_pkg::CP_MIN3) ||
                 (seq_len == u8v_pkg::LEN4 && code_acc < u8v_pkg::CP_MIN4) ||
                 code_acc > u8v_pkg::CP_MAX ||
                 (code_acc >= u8v_pkg::SURR_LO && code_acc <= u8v_pkg::SURR_HI))
          st = u8v_pkg::ST_NONCANON;
      end
    end
  endtask

  // Work out the verdict, if any, that an accepted byte causes
  task automatic predict_verdict(input logic [7:0] b, input logic eod);
    logic [2:0] st;
    if (!verdict_sent) begin
      decode_byte(b, st);
      if (st == u8v_pkg::ST_VALID && eod && cont_left != 2'd0)
        st = u8v_pkg::ST_TRUNC;
      if (st != u8v_pkg::ST_VALID || eod) begin
        expected_verdicts.insert(expected_verdicts.size(), st);
        verdict_sent = 1'b1;
      end
    end
    if (eod)
      clear_decoder();
  endtask

  task automatic note_failure(input string msg);
    fault_count++;
    if (fault_count <= 10)
      $display("%s", msg);
  endtask

  // Add one byte at the tail of the document being built
  task automatic put_byte(input logic [7:0] v);
    doc.insert(doc.size(), v);
  endtask

  // Queue the built document, marking its last byte
  task automatic push_document();
    doc_byte_t item;
    foreach (doc[i]) begin
      item.data_byte       = doc[i];
      item.end_of_document = (i == doc.size() - 1);
      pending_bytes.insert(pending_bytes.size(), item);
      bytes_queued++;
    end
    doc.delete();
  endtask

  task automatic append_code(input logic [20:0] cp, input int nbytes);
    case (nbytes)
      1: put_byte({1'b0, cp[6:0]});
      2: begin
        put_byte({3'b110, cp[10:6]});
        put_byte({2'b10, cp[5:0]});
      end
      3: begin
        put_byte({4'b1110, cp[15:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end
      default: begin
        put_byte({5'b11110, cp[20:18]});
        put_byte({2'b10, cp[17:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Append a well-formed character of the given encoded length
  task automatic append_valid_char(input int n);
    logic [20:0] cp;
    case (n)
      1: begin
        cp = 21'($urandom_range(8'h7f, u8v_pkg::PRINT_LO));
        if ($urandom_range(7) == 0) begin
          case ($urandom_range(2))
            0: cp = {13'd0, u8v_pkg::CHAR_TAB};
            1: cp = {13'd0, u8v_pkg::CHAR_LF};
            default: cp = {13'd0, u8v_pkg::CHAR_CR};
          endcase
        end
      end
      2: cp = 21'($urandom_range(12'h7ff, 12'h080));
      3: begin
        cp = 21'($urandom_range(16'hffff, u8v_pkg::CP_MIN3));
        // move surrogates up into the valid range 0xf800 to 0xffff
        if (cp >= u8v_pkg::SURR_LO && cp <= u8v_pkg::SURR_HI)
          cp = cp ^ 21'h002000;
      end
      default: cp = 21'($urandom_range(u8v_pkg::CP_MAX, u8v_pkg::CP_MIN4));
    endcase
    append_code(cp, n);
  endtask

  // Bits for a byte that cannot be a continuation
  function automatic logic [1:0] non_cont_bits();
    case ($urandom_range(2))
      0: return 2'b00;
      1: return 2'b01;
      default: return 2'b11;
    endcase
  endfunction

  // Append one malformed piece
  task automatic append_fault();
    int n;
    int pos;
    case ($urandom_range(6))
      0: begin
        if ($urandom_range(1))
          put_byte(8'($urandom_range(8'hc1, 8'h80)));
        else
          put_byte(8'($urandom_range(8'hff, 8'hf5)));
      end
      1: put_byte(8'($urandom_range(8'h1f, 8'h00)));
      2: begin
        n = $urandom_range(4, 2);
        append_valid_char(n);
        pos = doc.size() - $urandom_range(n - 1, 1);
        doc[pos][7:6] = non_cont_bits();
      end
      3: begin
        if ($urandom_range(1))
          append_code(21'($urandom_range(12'h7ff, 0)), 3);
        else
          append_code(21'($urandom_range(16'hffff, 0)), 4);
      end
      4: append_code(21'($urandom_range(u8v_pkg::SURR_HI, u8v_pkg::SURR_LO)), 3);
      5: append_code(21'($urandom_range(21'h13ffff, 21'h110000)), 4);
      default: put_byte(8'($urandom));
    endcase
  endtask

  // Leave a sequence open at the end, at times with a bad continuation in it
  task automatic append_cut_sequence();
    int n;
    int dropped;
    n = $urandom_range(4, 2);
    append_valid_char(n);
    dropped = $urandom_range(n - 1, 1);
    repeat (dropped) doc.delete(doc.size() - 1);
    if (dropped < n - 1 && $urandom_range(1))
      doc[doc.size() - 1][7:6] = non_cont_bits();
  endtask

  task automatic build_document();
    int n_chars;
    int kind;
    int fault_at;
    n_chars = $urandom_range(8, 1);
    kind    = $urandom_range(99);
    if (kind < 10) begin
      repeat ($urandom_range(6, 1)) put_byte(8'($urandom));
    end else begin
      fault_at = (kind < 55) ? $urandom_range(n_chars - 1, 0) : -1;
      for (int i = 0; i < n_chars; i++) begin
        if (i == fault_at)
          append_fault();
        else
          append_valid_char($urandom_range(4, 1));
      end
      if (kind >= 85)
        append_cut_sequence();
    end
    push_document();
  endtask

  function automatic bit link_drained();
    return pending_bytes.size() == 0 && !in_bus.valid && expected_verdicts.size() == 0;
  endfunction

  // Driver: present bytes and pace the result port on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid  <= 1'b0;
      out_bus.ready <= 1'b0;
    end else begin
      if (!in_bus.valid || in_fire) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_bytes.pop_front();
          in_bus.valid           <= 1'b1;
          in_bus.data_byte       <= next_item.data_byte;
          in_bus.end_of_document <= next_item.end_of_document;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: check verdicts and predict from accepted bytes on the rising edge
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_verdicts.size() == 0) begin
          note_failure($sformatf("unexpected verdict: got status %0d", out_bus.status_code));
        end else begin
          want_status = expected_verdicts.pop_front();
          if (out_bus.status_code !== want_status)
            note_failure($sformatf("verdict mismatch: expected status %0d, got %0d",
                                   want_status, out_bus.status_code));
        end
      end
      in_fire = in_bus.valid && in_bus.ready;
      if (in_fire)
        predict_verdict(in_bus.data_byte, in_bus.end_of_document);
    end
  end

  initial begin
    in_bus.valid           = 1'b0;
    in_bus.data_byte       = 8'h00;
    in_bus.end_of_document = 1'b0;
    out_bus.ready          = 1'b0;
    rst_n                  = 1'b0;
    in_fire                = 1'b0;
    cycle_count            = 0;
    fault_count            = 0;
    bytes_queued           = 0;
    send_idle_pct          = 0;
    stall_pct              = 0;
    clear_decoder();

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // Directed documents: edges of the byte ranges and each error kind
    doc = '{8'h41};                      push_document();
    doc = '{8'h00};                      push_document();
    doc = '{8'h09, 8'h0a, 8'h0d, 8'h7f}; push_document();
    doc = '{8'h1f};                      push_document();
    doc = '{8'hff};                      push_document();
    doc = '{8'hf4, 8'h8f, 8'hbf, 8'hbf}; push_document();
    // open sequence with a bad continuation ends as truncated
    doc = '{8'he1, 8'h41};               push_document();
    doc = '{8'he0, 8'h80, 8'h80};        push_document();
    doc = '{8'hed, 8'ha0, 8'h80};        push_document();
    // bytes after the verdict are ignored up to the end marker
    doc = '{8'hc3, 8'h28, 8'hc2};        push_document();
    doc = '{8'hf4, 8'h90, 8'h80, 8'h80}; push_document();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      bytes_queued = 0;
      while (bytes_queued < PHASE_BYTES) build_document();
      // hold the sender until every verdict of this phase is in
      while (!link_drained()) @(posedge clk);
      @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && expected_verdicts.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
